// ----- sv/fpa_pkg.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// fpa_pkg: shared types and constants of the Q24.8 fixed-point ALU
// Operation codes, the control bundle that rides with each item down the
// pipeline, and the default word and fraction widths.
// ---------------------------------------------------------------------------
package fpa_pkg;

  // port widths fixed by the item format
  localparam int unsigned DATA_W = 32;
  localparam int unsigned FUNC_W = 4;

  // default number format
  localparam int unsigned DEF_FRACTION_BITS = 8;
  localparam int unsigned DEF_WORD_BITS     = 32;

  // quotient bits resolved by each divider stage; the last stage may resolve fewer
  localparam int unsigned DIV_STEPS = 2;

  // operation codes
  typedef enum logic [FUNC_W-1:0] {
    OP_ADD      = 4'd0,
    OP_SUB      = 4'd1,
    OP_MUL      = 4'd2,
    OP_DIV      = 4'd3,
    OP_GT       = 4'd4,
    OP_LT       = 4'd5,
    OP_GE       = 4'd6,
    OP_LE       = 4'd7,
    OP_EQ       = 4'd8,
    OP_NE       = 4'd9,
    OP_MIN      = 4'd10,
    OP_MAX      = 4'd11,
    OP_INC      = 4'd12,
    OP_DEC      = 4'd13,
    OP_TO_INT   = 4'd14,
    OP_FROM_INT = 4'd15
  } op_e;

  // control bundle carried with each item
  typedef struct packed {
    op_e  op;    // operation of the item
    logic neg;   // quotient sign for divide
    logic dz;    // divide by zero
    logic dsat;  // quotient known to exceed the word range
    logic cmp;   // compare outcome
    logic ovf;   // saturation flag
  } ctl_t;

endpackage
`default_nettype wire

// ----- sv/fixed_point_q24_8_alu.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// fixed_point_q24_8_alu: pipelined signed Q24.8 arithmetic unit
// Add, subtract, rounded multiply and divide, compares, min/max, step and
// integer conversions, all saturating to the word range.
//
//   channel | handshake              | payload
//   --------+------------------------+--------------------------------------
//   in      | in_valid_i / in_ready_o | func_i, operand_a_i, operand_b_i
//   out     | out_valid_o/out_ready_i | result_raw_o, compare_true_o,
//           |                        | overflow_o, divide_by_zero_o
//
// One item enters per cycle while the output is not stalled. Items pass
// the front stages, the restoring divider that resolves up to two quotient
// bits per stage, and the back stages; every operation takes the same path.
// Reset clears only the stage valid bits.
// A stalled output freezes the whole pipeline, so in_ready_o follows
// out_ready_i whenever the output register is full.
// ---------------------------------------------------------------------------
module fixed_point_q24_8_alu #(
  parameter int unsigned FRACTION_BITS = fpa_pkg::DEF_FRACTION_BITS,
  parameter int unsigned WORD_BITS     = fpa_pkg::DEF_WORD_BITS
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [fpa_pkg::FUNC_W-1:0]        func_i,
  input  logic signed [fpa_pkg::DATA_W-1:0] operand_a_i,
  input  logic signed [fpa_pkg::DATA_W-1:0] operand_b_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic signed [fpa_pkg::DATA_W-1:0] result_raw_o,
  output logic                              compare_true_o,
  output logic                              overflow_o,
  output logic                              divide_by_zero_o
);
  import fpa_pkg::*;

  localparam int unsigned W         = WORD_BITS;
  localparam int unsigned F         = FRACTION_BITS;
  localparam int unsigned DIV_TOTAL = W + 1;
  localparam int unsigned NS        = (DIV_TOTAL + DIV_STEPS - 1) / DIV_STEPS;

  logic         en;
  logic [W-1:0] res_w;

  // divider chain signals, index 0 is the front end output
  logic         v_s    [NS+1];
  ctl_t         ctl_s  [NS+1];
  logic [W-1:0] side_s [NS+1];
  logic [W-1:0] den_s  [NS+1];
  logic [W:0]   dvd_s  [NS+1];
  logic [W-2:0] rem_s  [NS+1];
  logic [W:0]   quo_s  [NS+1];

  // global advance: move when the output register is free or being taken
  assign en         = !out_valid_o || out_ready_i;
  assign in_ready_o = en;

  // decode, simple ops, multiply, divider setup
  fpa_front #(
    .W (W),
    .F (F)
  ) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_valid_i),
    .op_i    (op_e'(func_i)),
    .a_i     ($signed(operand_a_i[W-1:0])),
    .b_i     ($signed(operand_b_i[W-1:0])),
    .valid_o (v_s[0]),
    .ctl_o   (ctl_s[0]),
    .side_o  (side_s[0]),
    .den_o   (den_s[0]),
    .dvd_o   (dvd_s[0]),
    .rem_o   (rem_s[0])
  );

  assign quo_s[0] = '0;

  // restoring divider stages
  for (genvar i = 0; i < NS; i++) begin : g_div
    localparam int unsigned LEFT  = DIV_TOTAL - i * DIV_STEPS;
    localparam int unsigned STEPS = (LEFT < DIV_STEPS) ? LEFT : DIV_STEPS;

    fpa_div_stage #(
      .W     (W),
      .STEPS (STEPS)
    ) u_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (v_s[i]),
      .ctl_i   (ctl_s[i]),
      .side_i  (side_s[i]),
      .den_i   (den_s[i]),
      .dvd_i   (dvd_s[i]),
      .rem_i   (rem_s[i]),
      .quo_i   (quo_s[i]),
      .valid_o (v_s[i+1]),
      .ctl_o   (ctl_s[i+1]),
      .side_o  (side_s[i+1]),
      .den_o   (den_s[i+1]),
      .dvd_o   (dvd_s[i+1]),
      .rem_o   (rem_s[i+1]),
      .quo_o   (quo_s[i+1])
    );
  end

  // rounding, final select and output register
  fpa_back #(
    .W (W)
  ) u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v_s[NS]),
    .ctl_i   (ctl_s[NS]),
    .side_i  (side_s[NS]),
    .quo_i   (quo_s[NS]),
    .valid_o (out_valid_o),
    .res_o   (res_w),
    .cmp_o   (compare_true_o),
    .ovf_o   (overflow_o),
    .dz_o    (divide_by_zero_o)
  );

  // sign-extend the word to the port width
  assign result_raw_o = DATA_W'($signed(res_w));

endmodule
`default_nettype wire

// ----- sv/fpa_front.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// fpa_front: decode, simple operations, multiply and divider setup
// Three register stages: operand decode with add/compare/shift ops and the
// signed product; product rounding add and divider preload; multiply
// saturation. Divide operands leave as divisor, dividend bits and remainder.
// ---------------------------------------------------------------------------
module fpa_front #(
  parameter int unsigned W = fpa_pkg::DEF_WORD_BITS,
  parameter int unsigned F = fpa_pkg::DEF_FRACTION_BITS
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               valid_i,
  input  fpa_pkg::op_e       op_i,
  input  logic signed [W-1:0] a_i,
  input  logic signed [W-1:0] b_i,
  output logic               valid_o,
  output fpa_pkg::ctl_t      ctl_o,
  output logic [W-1:0]       side_o,
  output logic [W-1:0]       den_o,
  output logic [W:0]         dvd_o,
  output logic [W-2:0]       rem_o
);
  import fpa_pkg::*;

  localparam logic [W-1:0]   MAX_W = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0]   MIN_W = {1'b1, {(W-1){1'b0}}};
  localparam logic [2*W-1:0] HALF  = (2*W)'(1) << (F-1);

  // stage 1 registers
  logic                 v1_q;
  ctl_t                 ctl1_d, ctl1_q;
  logic [W-1:0]         res1_d, res1_q;
  logic signed [2*W-1:0] prod1_q;
  logic [W-1:0]         amag1_q, bmag1_q;

  // stage 2 registers
  logic                 v2_q;
  ctl_t                 ctl2_d, ctl2_q;
  logic [W-1:0]         res2_q;
  logic [2*W-F-1:0]     mr2_d, mr2_q;
  logic                 pneg2_q;
  logic [W-1:0]         den2_q;
  logic [W:0]           dvd2_d, dvd2_q;
  logic [W-2:0]         rem2_d, rem2_q;

  // stage 3 next values
  ctl_t                 ctl3_d;
  logic [W-1:0]         res3_d;

  // stage 1: simple operations through one shared adder and compare
  always_comb begin
    logic signed [W:0] a_ext;
    logic signed [W:0] b_ext;
    logic signed [W:0] y;
    logic signed [W:0] s;
    logic              lt;
    logic              eq;
    logic              gt;
    logic [F:0]        top_bits;
    a_ext    = {a_i[W-1], a_i};
    b_ext    = {b_i[W-1], b_i};
    lt       = a_i < b_i;
    eq       = a_i == b_i;
    gt       = !lt && !eq;
    top_bits = a_i[W-1:W-1-F];
    case (op_i)
      OP_ADD:  y = b_ext;
      OP_SUB:  y = -b_ext;
      OP_INC:  y = (W+1)'(1);
      OP_DEC:  y = '1;
      default: y = '0;
    endcase
    s = a_ext + y;

    ctl1_d      = '0;
    ctl1_d.op   = op_i;
    ctl1_d.neg  = a_i[W-1] ^ b_i[W-1];
    ctl1_d.dz   = (op_i == OP_DIV) && (b_i == '0);
    res1_d      = '0;
    case (op_i)
      OP_ADD, OP_SUB, OP_INC, OP_DEC: begin
        ctl1_d.ovf = s[W] != s[W-1];
        res1_d     = ctl1_d.ovf ? (s[W] ? MIN_W : MAX_W) : s[W-1:0];
      end
      OP_GT:  ctl1_d.cmp = gt;
      OP_LT:  ctl1_d.cmp = lt;
      OP_GE:  ctl1_d.cmp = !lt;
      OP_LE:  ctl1_d.cmp = lt || eq;
      OP_EQ:  ctl1_d.cmp = eq;
      OP_NE:  ctl1_d.cmp = !eq;
      OP_MIN: res1_d = lt ? a_i : b_i;
      OP_MAX: res1_d = gt ? a_i : b_i;
      OP_TO_INT: res1_d = a_i >>> F;
      OP_FROM_INT: begin
        ctl1_d.ovf = !((&top_bits) || !(|top_bits));
        res1_d     = ctl1_d.ovf ? (a_i[W-1] ? MIN_W : MAX_W) : (a_i << F);
      end
      default: res1_d = '0;
    endcase
  end

  // stage 2: product magnitude plus half unit, divider preload
  always_comb begin
    logic [2*W-1:0] addend;
    logic [2*W-1:0] sum;
    logic [W+F:0]   dvd_wide;
    logic [2*W-1:0] num_x;
    logic [2*W-1:0] den_x;
    logic [W-1:0]   rem_full;
    addend   = prod1_q[2*W-1] ? ~prod1_q : prod1_q;
    sum      = addend + (prod1_q[2*W-1] ? HALF + (2*W)'(1) : HALF);
    mr2_d    = sum[2*W-1:F];
    dvd_wide = {amag1_q, {(F+1){1'b0}}};
    dvd2_d   = dvd_wide[W:0];
    rem_full = amag1_q >> (W-F);
    rem2_d   = rem_full[W-2:0];
    num_x    = {{W{1'b0}}, amag1_q} << F;
    den_x    = {bmag1_q, {W{1'b0}}};
    ctl2_d      = ctl1_q;
    ctl2_d.dsat = (ctl1_q.op == OP_DIV) && (num_x >= den_x);
  end

  // stage 3: multiply saturation and sign
  always_comb begin
    logic [2*W-1:0] m_x;
    logic           mov;
    m_x    = (2*W)'(mr2_q);
    mov    = (|m_x[2*W-1:W]) || (m_x[W-1] && (!pneg2_q || (|m_x[W-2:0])));
    ctl3_d = ctl2_q;
    res3_d = res2_q;
    if (ctl2_q.op == OP_MUL) begin
      ctl3_d.ovf = mov;
      if (mov) begin
        res3_d = pneg2_q ? MIN_W : MAX_W;
      end else begin
        res3_d = pneg2_q ? -m_x[W-1:0] : m_x[W-1:0];
      end
    end
  end

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q    <= 1'b0;
      v2_q    <= 1'b0;
      valid_o <= 1'b0;
    end else if (en_i) begin
      v1_q    <= valid_i;
      v2_q    <= v1_q;
      valid_o <= v2_q;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ctl1_q  <= ctl1_d;
      res1_q  <= res1_d;
      prod1_q <= a_i * b_i;
      amag1_q <= a_i[W-1] ? (~a_i + W'(1)) : a_i;
      bmag1_q <= b_i[W-1] ? (~b_i + W'(1)) : b_i;

      ctl2_q  <= ctl2_d;
      res2_q  <= res1_q;
      mr2_q   <= mr2_d;
      pneg2_q <= prod1_q[2*W-1];
      den2_q  <= bmag1_q;
      dvd2_q  <= dvd2_d;
      rem2_q  <= rem2_d;

      ctl_o   <= ctl3_d;
      side_o  <= res3_d;
      den_o   <= den2_q;
      dvd_o   <= dvd2_q;
      rem_o   <= rem2_q;
    end
  end

endmodule
`default_nettype wire

// ----- sv/fpa_div_stage.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// fpa_div_stage: one stage of the restoring divider
// Resolves STEPS quotient bits by shift, compare and subtract, then
// registers the partial state together with the item's side results.
// ---------------------------------------------------------------------------
module fpa_div_stage #(
  parameter int unsigned W     = fpa_pkg::DEF_WORD_BITS,
  parameter int unsigned STEPS = fpa_pkg::DIV_STEPS
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  fpa_pkg::ctl_t ctl_i,
  input  logic [W-1:0]  side_i,
  input  logic [W-1:0]  den_i,
  input  logic [W:0]    dvd_i,
  input  logic [W-2:0]  rem_i,
  input  logic [W:0]    quo_i,
  output logic          valid_o,
  output fpa_pkg::ctl_t ctl_o,
  output logic [W-1:0]  side_o,
  output logic [W-1:0]  den_o,
  output logic [W:0]    dvd_o,
  output logic [W-2:0]  rem_o,
  output logic [W:0]    quo_o
);
  import fpa_pkg::*;

  logic [W:0]   dvd_d;
  logic [W-2:0] rem_d;
  logic [W:0]   quo_d;

  // shift in the next dividend bit, subtract the divisor when it fits
  always_comb begin
    logic [W-1:0] trial;
    logic [W-1:0] diff;
    dvd_d = dvd_i;
    rem_d = rem_i;
    quo_d = quo_i;
    for (int unsigned s = 0; s < STEPS; s++) begin
      trial = {rem_d, dvd_d[W]};
      dvd_d = dvd_d << 1;
      diff  = trial - den_i;
      if (trial >= den_i) begin
        rem_d = diff[W-2:0];
        quo_d = {quo_d[W-1:0], 1'b1};
      end else begin
        rem_d = trial[W-2:0];
        quo_d = {quo_d[W-1:0], 1'b0};
      end
    end
  end

  // valid bit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else if (en_i) begin
      valid_o <= valid_i;
    end
  end

  // partial quotient state and side results
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ctl_o  <= ctl_i;
      side_o <= side_i;
      den_o  <= den_i;
      dvd_o  <= dvd_d;
      rem_o  <= rem_d;
      quo_o  <= quo_d;
    end
  end

endmodule
`default_nettype wire

// ----- sv/fpa_back.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// fpa_back: quotient rounding and result select
// First stage rounds the doubled quotient and checks the word range; the
// second applies the sign, saturates and forms the output register.
// ---------------------------------------------------------------------------
module fpa_back #(
  parameter int unsigned W = fpa_pkg::DEF_WORD_BITS
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  fpa_pkg::ctl_t ctl_i,
  input  logic [W-1:0]  side_i,
  input  logic [W:0]    quo_i,
  output logic          valid_o,
  output logic [W-1:0]  res_o,
  output logic          cmp_o,
  output logic          ovf_o,
  output logic          dz_o
);
  import fpa_pkg::*;

  localparam logic [W-1:0] MAX_W = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] MIN_W = {1'b1, {(W-1){1'b0}}};

  logic         va_q;
  ctl_t         ctla_d, ctla_q;
  logic [W-1:0] sidea_q;
  logic [W-1:0] mga_d, mga_q;
  logic [W-1:0] res_d;

  // round half away from zero and check the range
  always_comb begin
    logic [W+1:0] qp1;
    logic [W:0]   q;
    qp1    = {1'b0, quo_i} + (W+2)'(1);
    q      = qp1[W+1:1];
    mga_d  = q[W-1:0];
    ctla_d = ctl_i;
    if (ctl_i.op == OP_DIV) begin
      ctla_d.ovf = !ctl_i.dz && (ctl_i.dsat || q[W] ||
                   (q[W-1] && (!ctl_i.neg || (|q[W-2:0]))));
    end
  end

  // final select
  always_comb begin
    res_d = sidea_q;
    if (ctla_q.op == OP_DIV) begin
      if (ctla_q.dz) begin
        res_d = '0;
      end else if (ctla_q.ovf) begin
        res_d = ctla_q.neg ? MIN_W : MAX_W;
      end else begin
        res_d = ctla_q.neg ? -mga_q : mga_q;
      end
    end
  end

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q    <= 1'b0;
      valid_o <= 1'b0;
    end else if (en_i) begin
      va_q    <= valid_i;
      valid_o <= va_q;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ctla_q  <= ctla_d;
      sidea_q <= side_i;
      mga_q   <= mga_d;
      res_o   <= res_d;
      cmp_o   <= ctla_q.cmp;
      ovf_o   <= ctla_q.ovf;
      dz_o    <= ctla_q.dz;
    end
  end

endmodule
`default_nettype wire

// ----- test/tb_top.sv -----
// ---------------------------------------------------------------------------
// tb_top: testbench of the pipelined Q24.8 fixed-point ALU
// Drives operand pairs through the valid/ready input channel, predicts every
// result with 64-bit arithmetic at the default widths, and checks each
// output item field by field in order. Directed corner cases come first,
// then random operations with and without input gaps and output stalls.
// ---------------------------------------------------------------------------
module tb_top;
  import fpa_pkg::*;

  // expected content of one output item
  typedef struct packed {
    logic signed [31:0] word;
    logic               cmp;
    logic               ovf;
    logic               dz;
  } alu_result_t;

  localparam logic signed [31:0] WORD_MAX = 32'sh7fff_ffff;
  localparam logic signed [31:0] WORD_MIN = 32'sh8000_0000;
  localparam int unsigned FRAC = DEF_FRACTION_BITS;

  logic                     clk;
  logic                     rst_n;
  logic                     in_valid;
  logic                     in_ready;
  logic [FUNC_W-1:0]        func;
  logic signed [DATA_W-1:0] operand_a;
  logic signed [DATA_W-1:0] operand_b;
  logic                     out_valid;
  logic                     out_ready;
  logic signed [DATA_W-1:0] result_raw;
  logic                     compare_true;
  logic                     overflow;
  logic                     divide_by_zero;

  alu_result_t pending_results[$];
  int          error_count   = 0;
  int          in_gap_max    = 12;
  int          out_stall_max = 12;
  int          stall_left    = 0;

  fixed_point_q24_8_alu i_dut (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_ready_o       (in_ready),
    .func_i           (func),
    .operand_a_i      (operand_a),
    .operand_b_i      (operand_b),
    .out_valid_o      (out_valid),
    .out_ready_i      (out_ready),
    .result_raw_o     (result_raw),
    .compare_true_o   (compare_true),
    .overflow_o       (overflow),
    .divide_by_zero_o (divide_by_zero)
  );

  // clock and reset
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    rst_n = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
  end

  // clamp to the word range, overflow flag in the top bit
  function automatic logic [32:0] saturate(longint v);
    if (v > longint'(WORD_MAX)) begin
      return {1'b1, WORD_MAX};
    end
    if (v < longint'(WORD_MIN)) begin
      return {1'b1, WORD_MIN};
    end
    return {1'b0, v[31:0]};
  endfunction

  // exact result of one operation at the default number format
  function automatic alu_result_t alu_predict(op_e op, logic signed [31:0] a,
                                              logic signed [31:0] b);
    alu_result_t          r;
    longint               sa;
    longint               sb;
    longint               wide;
    longint unsigned      mag;
    longint unsigned      num;
    longint unsigned      den;
    logic [32:0]          sat;
    r = '0;
    sa = a;
    sb = b;
    sat = '0;
    case (op)
      OP_ADD: sat = saturate(sa + sb);
      OP_SUB: sat = saturate(sa - sb);
      OP_MUL: begin
        // product rounded half away from zero
        wide = sa * sb;
        mag = (wide < 0) ? longint'(-wide) : wide;
        mag = (mag + (64'd1 << (FRAC - 1))) >> FRAC;
        sat = saturate((wide < 0) ? -longint'(mag) : longint'(mag));
      end
      OP_DIV: begin
        if (sb == 0) begin
          r.dz = 1'b1;
        end else begin
          // quotient rounded half away from zero
          num = ((sa < 0) ? longint'(-sa) : sa) << FRAC;
          den = (sb < 0) ? longint'(-sb) : sb;
          mag = (64'd2 * num + den) / (64'd2 * den);
          sat = saturate(((sa < 0) != (sb < 0)) ? -longint'(mag) : longint'(mag));
        end
      end
      OP_GT:  r.cmp = (sa > sb);
      OP_LT:  r.cmp = (sa < sb);
      OP_GE:  r.cmp = (sa >= sb);
      OP_LE:  r.cmp = (sa <= sb);
      OP_EQ:  r.cmp = (sa == sb);
      OP_NE:  r.cmp = (sa != sb);
      OP_MIN: sat = {1'b0, (sa < sb) ? a : b};
      OP_MAX: sat = {1'b0, (sa > sb) ? a : b};
      OP_INC: sat = saturate(sa + 1);
      OP_DEC: sat = saturate(sa - 1);
      // floor of the value, never overflows
      OP_TO_INT: sat = {1'b0, a >>> FRAC};
      default: sat = saturate(sa * (longint'(1) << FRAC));
    endcase
    r.word = sat[31:0];
    r.ovf  = sat[32];
    return r;
  endfunction

  // drive one item and record its expected result once accepted
  task automatic send_op(op_e op, logic signed [31:0] a, logic signed [31:0] b);
    int gap;
    gap = (in_gap_max == 0) ? 0 : $urandom_range(0, in_gap_max);
    @(negedge clk);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid  = 1'b1;
    func      = op;
    operand_a = a;
    operand_b = b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_results.push_back(alu_predict(op, a, b));
  endtask

  // hold the input idle until every pending result has been checked
  task automatic drain_results();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // operand biased toward the range ends and small values
  function automatic logic signed [31:0] pick_operand();
    case ($urandom_range(0, 7))
      0: return WORD_MAX - $urandom_range(0, 3);
      1: return WORD_MIN + $urandom_range(0, 3);
      2: return int'($urandom_range(0, 1023)) - 512;
      3: return int'($urandom_range(0, 1 << 20)) - (1 << 19);
      4: return int'($urandom_range(0, 1 << 12)) << $urandom_range(0, 20);
      default: return $urandom();
    endcase
  endfunction

  // receiver: random stall before taking each item
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        out_ready = 1'b0;
        stall_left--;
      end else begin
        out_ready = 1'b1;
      end
    end
  end

  // compare each output item with the oldest prediction
  initial begin
    alu_result_t want;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) begin
        stall_left = (out_stall_max == 0) ? 0 : $urandom_range(0, out_stall_max);
        if (pending_results.size() == 0) begin
          $display("%0t: unexpected item, got result %h", $time, result_raw);
          error_count++;
        end else begin
          want = pending_results.pop_front();
          if (result_raw !== want.word) begin
            $display("%0t: result_raw expected %h, got %h", $time, want.word, result_raw);
            error_count++;
          end
          if (compare_true !== want.cmp) begin
            $display("%0t: compare_true expected %b, got %b", $time, want.cmp,
                     compare_true);
            error_count++;
          end
          if (overflow !== want.ovf) begin
            $display("%0t: overflow expected %b, got %b", $time, want.ovf, overflow);
            error_count++;
          end
          if (divide_by_zero !== want.dz) begin
            $display("%0t: divide_by_zero expected %b, got %b", $time, want.dz,
                     divide_by_zero);
            error_count++;
          end
        end
      end
    end
  end

  // add and subtract at the range ends
  task automatic test_add_sub();
    send_op(OP_ADD, WORD_MAX, 32'sd1);
    send_op(OP_ADD, WORD_MIN, -32'sd1);
    send_op(OP_SUB, WORD_MIN, 32'sd1);
    send_op(OP_SUB, WORD_MAX, WORD_MIN);
  endtask

  // rounding, saturation and divide by zero
  task automatic test_mul_div();
    send_op(OP_MUL, WORD_MAX, WORD_MAX);
    send_op(OP_MUL, WORD_MIN, WORD_MIN);
    send_op(OP_MUL, WORD_MIN, WORD_MAX);
    send_op(OP_MUL, -32'sd1, 32'sd128);
    send_op(OP_DIV, 32'sh1234_5678, 32'sd0);
    send_op(OP_DIV, WORD_MIN, -32'sd256);
    send_op(OP_DIV, 32'sd1, 32'sd3);
    send_op(OP_DIV, -32'sd1, 32'sd512);
  endtask

  // every compare, plus min and max
  task automatic test_compare_minmax();
    send_op(OP_GT, WORD_MIN, WORD_MAX);
    send_op(OP_LT, WORD_MIN, WORD_MAX);
    send_op(OP_GE, 32'sd5, 32'sd5);
    send_op(OP_LE, WORD_MAX, WORD_MIN);
    send_op(OP_EQ, -32'sd7, -32'sd7);
    send_op(OP_NE, -32'sd1, -32'sd1);
    send_op(OP_MIN, WORD_MIN, WORD_MAX);
    send_op(OP_MAX, WORD_MIN, WORD_MAX);
  endtask

  // step and integer conversions at the range ends
  task automatic test_unary();
    send_op(OP_INC, WORD_MAX, 32'sd0);
    send_op(OP_DEC, WORD_MIN, 32'sd0);
    send_op(OP_TO_INT, WORD_MIN, 32'sd0);
    send_op(OP_TO_INT, -32'sd1, 32'sd0);
    send_op(OP_FROM_INT, 32'sh0080_0000, 32'sd0);
    send_op(OP_FROM_INT, -32'sh0080_0000, 32'sd0);
  endtask

  // random operations, idling switched on and off in stretches
  task automatic test_random_mix(int count);
    op_e                op;
    logic signed [31:0] a;
    logic signed [31:0] b;
    for (int i = 0; i < count; i++) begin
      if (i % 40 == 0) begin
        in_gap_max    = $urandom_range(0, 1) ? 12 : 0;
        out_stall_max = $urandom_range(0, 1) ? 12 : 0;
      end
      op = op_e'($urandom_range(0, 15));
      a  = pick_operand();
      b  = pick_operand();
      if (op == OP_DIV && $urandom_range(0, 5) == 0) begin
        b = 32'sd0;
      end
      if (op inside {OP_GT, OP_LT, OP_GE, OP_LE, OP_EQ, OP_NE, OP_MIN, OP_MAX} &&
          $urandom_range(0, 3) == 0) begin
        b = a;
      end
      send_op(op, a, b);
      if ($urandom_range(0, 59) == 0) begin
        drain_results();
      end
    end
  endtask

  // full rate on both sides
  task automatic test_back_to_back(int count);
    in_gap_max    = 0;
    out_stall_max = 0;
    for (int i = 0; i < count; i++) begin
      send_op(op_e'($urandom_range(0, 15)), pick_operand(), pick_operand());
    end
  endtask

  // full rate input against a stalling output
  task automatic test_stalled_output(int count);
    in_gap_max    = 0;
    out_stall_max = 12;
    for (int i = 0; i < count; i++) begin
      send_op(op_e'($urandom_range(0, 15)), pick_operand(), pick_operand());
    end
  endtask

  // test sequence
  initial begin
    in_valid  = 1'b0;
    func      = OP_ADD;
    operand_a = '0;
    operand_b = '0;
    @(posedge rst_n);
    test_add_sub();
    test_mul_div();
    drain_results();
    test_compare_minmax();
    test_unary();
    drain_results();
    test_random_mix(400);
    drain_results();
    test_back_to_back(150);
    drain_results();
    test_stalled_output(100);
    drain_results();
    repeat (40) @(posedge clk);
    if (error_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // run limit
  initial begin
    #2_000_000;
    $display("FAIL");
    $finish;
  end

endmodule
